// ===== design/qcsd_pkg.sv =====
// Shared types, codes, constants and lookup functions of the quadrature counter block.
package qcsd_pkg;

  // Fixed field and register widths.
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned SHOWN_W    = 14;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned DIGIT_W    = 2;
  localparam int unsigned PINS_W     = 2;
  localparam int unsigned STEP_W     = 2;
  localparam int unsigned DIR_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned BCD_W      = 16;
  localparam int unsigned BCD_CNT_W  = 4;
  localparam int unsigned NUM_DIGITS = 4;

  // Reset values and fixed constants.
  localparam logic [LIMIT_W-1:0] SHRINK_RESET = 16'd3000;
  localparam logic [LIMIT_W-1:0] GROW_RESET   = 16'd10;
  localparam int unsigned        PERIOD_RESET = 1000;
  localparam int unsigned        DISPLAY_MOD  = 10000;
  localparam int unsigned        PERIOD_DIV   = 10;

  // Direction sum values that mark a full detent.
  localparam logic signed [DIR_W-1:0] DIR_FWD  = 4'sd4;
  localparam logic signed [DIR_W-1:0] DIR_BACK = -4'sd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHRINK_LIMIT = 1'b0,
    REG_GROW_LIMIT   = 1'b1
  } cfg_reg_e;

  // Detent code reported with each result.
  typedef enum logic [STEP_W-1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_BACK = 2'd2
  } step_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CNT,
    ST_MAG,
    ST_BCD,
    ST_OUT
  } state_e;

  // What the shared serial divider is working on.
  typedef enum logic [1:0] {
    OP_PERIOD,
    OP_TICK,
    OP_MAG
  } div_op_e;

  // Input item.
  typedef struct packed {
    logic              mode;
    logic [PINS_W-1:0] enc_pins;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [DIGIT_W-1:0] digit_index;
    logic               led;
    logic [STEP_W-1:0]  step;
    logic [SHOWN_W-1:0] shown_value;
  } out_item_t;

  // Quadrature transition table indexed by {previous pins, current pins}.
  function automatic logic signed [2:0] trans_lookup(input logic [3:0] idx);
    logic signed [2:0] v;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: v = -3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: v = 3'sd1;
      default:                  v = 3'sd0;
    endcase
    return v;
  endfunction

  // Seven-segment pattern of one decimal digit, segment a in bit 0.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/qcsd_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
interface qcsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/quadrature_counter_segment_display.sv =====
// Quadrature encoder counter with blinking LED period and four-digit display scan.
//
// Each input item is either an encoder pin sample (mode 0) or a one millisecond
// tick (mode 1), and each produces exactly one result. A sample without a detent
// goes straight from the transfer to the output state. A detent runs the period
// update through the shared bit-serial divider (width DW = max(COUNT_WIDTH,
// PERIOD_WIDTH + 1)) when the period limit allows it, then, if the count changes,
// the magnitude of the count modulo 10000 through the same divider. A tick runs
// the blink counter modulo through the divider and then a 14-step serial
// binary-to-BCD conversion of the shown value for the scanned digit. The divider
// retires one quotient bit per cycle. One item is in work at a time; a finished
// result waits in the output register while the next item is taken. The user
// must write the limit registers through cfg_we_i, cfg_idx_i and cfg_wdata_i only
// while the block is idle; the block itself does not enforce this.
module quadrature_counter_segment_display #(
  parameter int unsigned COUNT_WIDTH  = 32,
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  qcsd_stream_if.sink                       in_i,
  qcsd_stream_if.source                     out_o,
  input  logic                              cfg_we_i,
  input  logic [qcsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qcsd_pkg::LIMIT_W-1:0]      cfg_wdata_i
);
  import qcsd_pkg::*;

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned PW    = PERIOD_WIDTH;
  localparam int unsigned DW    = (CW > PW + 1) ? CW : PW + 1;
  localparam int unsigned VW    = (PW > SHOWN_W) ? PW : SHOWN_W;
  localparam int unsigned LW    = (PW > LIMIT_W) ? PW : LIMIT_W;
  localparam int unsigned CNT_W = $clog2(DW + 1);

  // Architectural state.
  state_e                   state_q, state_d;
  logic [PINS_W-1:0]        prev_q;
  logic signed [DIR_W-1:0]  dir_q;
  logic [PW-1:0]            period_q;
  logic [PW-1:0]            tick_q;
  logic                     led_q;
  logic [CW-1:0]            count_q;
  logic [DIGIT_W-1:0]       scan_q;
  logic [SEG_W-1:0]         seg_q;
  logic [DIGIT_W-1:0]       digit_q;
  logic [LIMIT_W-1:0]       shrink_q;
  logic [LIMIT_W-1:0]       grow_q;
  logic [SHOWN_W-1:0]       shown_q;
  logic                     out_valid_q;

  // Work registers.
  step_e                    step_q;
  logic                     pins_nz_q;
  div_op_e                  op_q;
  logic [DW-1:0]            dv_q;
  logic [VW-1:0]            rem_q;
  logic [VW-1:0]            dvsr_q;
  logic [CNT_W-1:0]         div_cnt_q;
  logic [SHOWN_W-1:0]       bin_q;
  logic [BCD_W-1:0]         bcd_q;
  logic [BCD_CNT_W-1:0]     bcd_cnt_q;
  out_item_t                out_q;

  // Combinational signals.
  logic                     in_acc;
  logic                     out_free;
  logic signed [DIR_W-1:0]  sum_new;
  logic                     is_fwd;
  logic                     is_back;
  logic                     shrink_go;
  logic                     grow_go;
  logic                     cnt_changes;
  logic [VW:0]              partial;
  logic                     div_ge;
  logic [VW:0]              partial_sub;
  logic [PW-1:0]            quot;
  logic [PW:0]              grown;
  logic [CW-1:0]            count_mag;
  logic [BCD_W-1:0]         bcd_adj;
  logic [3:0]               cur_digit;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Transition table lookup and detent decision.
  assign sum_new   = dir_q + DIR_W'(trans_lookup({prev_q, in_i.payload.enc_pins}));
  assign is_fwd    = (sum_new == DIR_FWD);
  assign is_back   = (sum_new == DIR_BACK);
  assign shrink_go = is_fwd && (LW'(period_q) < LW'(shrink_q));
  assign grow_go   = is_back && (LW'(period_q) > LW'(grow_q));

  assign cnt_changes = ((step_q == STEP_FWD) && pins_nz_q) || (step_q == STEP_BACK);

  // One restoring division step: bring down the next dividend bit.
  assign partial     = {rem_q, dv_q[DW-1]};
  assign div_ge      = (partial >= {1'b0, dvsr_q});
  assign partial_sub = partial - {1'b0, dvsr_q};

  // Period update from the quotient of period / 10.
  assign quot  = dv_q[PW-1:0];
  assign grown = {1'b0, period_q} + {1'b0, quot};

  // Magnitude of the two's complement count.
  assign count_mag = count_q[CW-1] ? (CW'(0) - count_q) : count_q;

  // Add-three correction of each BCD digit before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                   : bcd_q[4*i +: 4];
    end
  end

  assign cur_digit = bcd_q[4*scan_q +: 4];

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_i.payload.mode) state_d = ST_DIV;
          else if (!is_fwd && !is_back) state_d = ST_OUT;
          else if (shrink_go || grow_go) state_d = ST_DIV;
          else state_d = ST_CNT;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          unique case (op_q)
            OP_PERIOD: state_d = ST_CNT;
            OP_TICK:   state_d = ST_BCD;
            OP_MAG:    state_d = ST_OUT;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_CNT: state_d = cnt_changes ? ST_MAG : ST_OUT;
      ST_MAG: state_d = ST_DIV;
      ST_BCD: begin
        if (bcd_cnt_q == '0) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Architectural state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      dir_q       <= '0;
      period_q    <= PW'(PERIOD_RESET);
      tick_q      <= '0;
      led_q       <= 1'b0;
      count_q     <= '0;
      scan_q      <= '0;
      seg_q       <= '0;
      digit_q     <= '0;
      shrink_q    <= SHRINK_RESET;
      grow_q      <= GROW_RESET;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SHRINK_LIMIT) shrink_q <= cfg_wdata_i;
        if (cfg_idx_i == REG_GROW_LIMIT) grow_q <= cfg_wdata_i;
      end

      // Encoder sample bookkeeping.
      if (in_acc && !in_i.payload.mode) begin
        prev_q <= in_i.payload.enc_pins;
        dir_q  <= (is_fwd || is_back) ? '0 : sum_new;
      end

      // Divider results.
      if (state_q == ST_DIV && div_cnt_q == '0) begin
        unique case (op_q)
          OP_PERIOD: begin
            if (step_q == STEP_FWD) begin
              period_q <= period_q - quot;
            end else begin
              period_q <= grown[PW] ? {PW{1'b1}} : grown[PW-1:0];
            end
          end
          OP_TICK: begin
            tick_q <= rem_q[PW-1:0];
            if (rem_q == '0) led_q <= !led_q;
          end
          OP_MAG:  shown_q <= rem_q[SHOWN_W-1:0];
          default: shown_q <= shown_q;
        endcase
      end

      // Position count.
      if (state_q == ST_CNT) begin
        if (step_q == STEP_BACK) begin
          count_q <= count_q - CW'(1);
        end else if (cnt_changes) begin
          count_q <= count_q + CW'(1);
        end
      end

      // Drive the scanned digit once its BCD value is ready.
      if (state_q == ST_BCD && bcd_cnt_q == '0) begin
        seg_q   <= seg_lookup(cur_digit);
        digit_q <= scan_q;
        scan_q  <= scan_q + DIGIT_W'(1);
      end

      // Output register handshake.
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider, BCD converter and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pins_nz_q <= |in_i.payload.enc_pins;
      priority if (in_i.payload.mode) step_q <= STEP_NONE;
      else if (is_fwd) step_q <= STEP_FWD;
      else if (is_back) step_q <= STEP_BACK;
      else step_q <= STEP_NONE;

      // Blink counter modulo the period, or a tenth of the period.
      if (in_i.payload.mode) begin
        op_q      <= OP_TICK;
        dv_q      <= DW'({1'b0, tick_q} + (PW + 1)'(1));
        dvsr_q    <= (period_q == '0) ? VW'(1) : VW'(period_q);
        rem_q     <= '0;
        div_cnt_q <= CNT_W'(DW);
      end else if (shrink_go || grow_go) begin
        op_q      <= OP_PERIOD;
        dv_q      <= DW'(period_q);
        dvsr_q    <= VW'(PERIOD_DIV);
        rem_q     <= '0;
        div_cnt_q <= CNT_W'(DW);
      end
    end

    // Displayed magnitude: count modulo 10000.
    if (state_q == ST_MAG) begin
      op_q      <= OP_MAG;
      dv_q      <= DW'(count_mag);
      dvsr_q    <= VW'(DISPLAY_MOD);
      rem_q     <= '0;
      div_cnt_q <= CNT_W'(DW);
    end

    // One quotient bit per cycle.
    if (state_q == ST_DIV && div_cnt_q != '0) begin
      rem_q     <= div_ge ? partial_sub[VW-1:0] : partial[VW-1:0];
      dv_q      <= {dv_q[DW-2:0], div_ge};
      div_cnt_q <= div_cnt_q - CNT_W'(1);
    end

    // Start the BCD conversion after the tick division.
    if (state_q == ST_DIV && div_cnt_q == '0 && op_q == OP_TICK) begin
      bin_q     <= shown_q;
      bcd_q     <= '0;
      bcd_cnt_q <= BCD_CNT_W'(SHOWN_W);
    end

    // Shift one binary bit into the BCD digits per cycle.
    if (state_q == ST_BCD && bcd_cnt_q != '0) begin
      bcd_q     <= {bcd_adj[BCD_W-2:0], bin_q[SHOWN_W-1]};
      bin_q     <= {bin_q[SHOWN_W-2:0], 1'b0};
      bcd_cnt_q <= bcd_cnt_q - BCD_CNT_W'(1);
    end

    // Capture the result.
    if (state_q == ST_OUT && out_free) begin
      out_q.segments    <= seg_q;
      out_q.digit_index <= digit_q;
      out_q.led         <= led_q;
      out_q.step        <= step_q;
      out_q.shown_value <= shown_q;
    end
  end

endmodule

// ===== design/qcsd_checker.sv =====
// Port-level checker for the quadrature counter block and its bind statement.
module qcsd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [qcsd_pkg::STEP_W-1:0]    out_step_i,
  input logic [qcsd_pkg::SHOWN_W-1:0]   out_shown_i,
  input logic [qcsd_pkg::SEG_W-1:0]     out_seg_i
);
  import qcsd_pkg::*;

  // The block works on one item at a time, so it is busy right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while previous item still in work");

  // The displayed magnitude is a remainder of 10000.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_shown_i < SHOWN_W'(DISPLAY_MOD)))
    else $error("shown value out of range");

  // Only the three detent codes are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_step_i == STEP_NONE || out_step_i == STEP_FWD ||
                     out_step_i == STEP_BACK))
    else $error("invalid step code");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_shown_i) && $stable(out_seg_i)))
    else $error("stalled result changed");

endmodule

bind quadrature_counter_segment_display qcsd_checker u_qcsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_step_i  (out_o.payload.step),
  .out_shown_i (out_o.payload.shown_value),
  .out_seg_i   (out_o.payload.segments)
);
